// ----- design/eprc_pkg.sv -----
package eprc_pkg;

	localparam int VERTEX_W  = 12;
	localparam int PART_W    = 4;
	localparam int VCOUNT_W  = 13;
	localparam int PCOUNT_W  = 5;
	localparam int TOTAL_W   = 17;
	localparam int NEW_W     = 2;
	localparam int WORD_W    = 32;
	localparam int BIT_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 13;

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 13'd4096;
	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VERTEX_COUNT    = 2'd0,
		CFG_PARTITION_COUNT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic                action;
		logic [VERTEX_W-1:0] vertex_a;
		logic [VERTEX_W-1:0] vertex_b;
		logic [PART_W-1:0]   partition;
	} edge_word_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] replica_total;
		logic [NEW_W-1:0]   new_replicas;
		logic               range_error;
	} result_word_t;

	typedef struct packed {
		logic [VCOUNT_W-1:0] vertex_count;
		logic [PCOUNT_W-1:0] partition_count;
	} cfg_limits_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_status_t;

endpackage

// ----- design/eprc_result_fifo.sv -----
module eprc_result_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  eprc_pkg::result_word_t push_word,
	output eprc_pkg::fifo_status_t status,
	output logic                  result_valid,
	input  logic                  result_stall,
	output eprc_pkg::result_word_t result_word
);

	eprc_pkg::result_word_t slot_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;
	logic                   pop;

	assign pop          = result_valid && !result_stall;
	assign result_valid = (count_q != 2'd0);
	assign result_word  = slot_q[rd_ptr_q];
	assign status.empty = (count_q == 2'd0);
	assign status.full  = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- design/eprc_bitmap_core.sv -----
module eprc_bitmap_core #(
	parameter int MAX_VERTICES   = 4096,
	parameter int MAX_PARTITIONS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   edge_valid,
	input  eprc_pkg::edge_word_t   edge_word,
	output logic                   edge_stall,
	input  eprc_pkg::cfg_limits_t  limits,
	input  eprc_pkg::fifo_status_t fifo_stat,
	output logic                   push,
	output eprc_pkg::result_word_t push_word
);

	localparam longint TOTAL  = longint'(MAX_VERTICES) * longint'(MAX_PARTITIONS);
	localparam int     ROWS   = int'((TOTAL + eprc_pkg::WORD_W - 1) / eprc_pkg::WORD_W);
	localparam int     ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int     POS_W  = ROW_AW + eprc_pkg::BIT_W;

	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_RDB  = 5'b00100,
		ST_WRB  = 5'b01000,
		ST_ERR  = 5'b10000
	} state_t;

	state_t st_q;

	logic [eprc_pkg::WORD_W-1:0] mem [ROWS];
	logic [eprc_pkg::WORD_W-1:0] rdata_q;
	logic [ROW_AW-1:0]           rd_row_q;
	logic                        fwd_valid_q;
	logic [ROW_AW-1:0]           fwd_row_q;
	logic [eprc_pkg::WORD_W-1:0] fwd_data_q;

	logic [ROW_AW-1:0]          row_a_q, row_b_q;
	logic [eprc_pkg::BIT_W-1:0] bit_a_q, bit_b_q;
	logic                       new_a_q;
	logic [eprc_pkg::TOTAL_W-1:0] count_q;
	logic [ROW_AW-1:0]          sweep_q;
	logic                       clr_item_q;

	logic                        accept;
	logic                        in_range;
	logic [POS_W-1:0]            pos_a, pos_b;
	logic                        rd_en;
	logic [ROW_AW-1:0]           rd_row;
	logic                        wr_en;
	logic [ROW_AW-1:0]           wr_row;
	logic [eprc_pkg::WORD_W-1:0] wr_data;
	logic [eprc_pkg::WORD_W-1:0] rdata_eff;
	logic                        new_a, new_b;
	logic                        sweep_last;
	logic [eprc_pkg::TOTAL_W-1:0] count_a, count_b;

	function automatic logic [eprc_pkg::TOTAL_W-1:0] sat_inc(
		input logic [eprc_pkg::TOTAL_W-1:0] val,
		input logic                         en
	);
		if (en && (val != '1)) begin
			return val + 1'b1;
		end
		return val;
	endfunction

	assign edge_stall = !(((st_q == ST_IDLE) && !fifo_stat.full) ||
		((st_q == ST_WRB) && fifo_stat.empty));
	assign accept = edge_valid && !edge_stall;

	// limit is the smaller of the register and the build-time maximum
	assign in_range =
		(32'(edge_word.vertex_a) < 32'(MAX_VERTICES)) &&
		({1'b0, edge_word.vertex_a} < limits.vertex_count) &&
		(32'(edge_word.vertex_b) < 32'(MAX_VERTICES)) &&
		({1'b0, edge_word.vertex_b} < limits.vertex_count) &&
		(32'(edge_word.partition) < 32'(MAX_PARTITIONS)) &&
		({1'b0, edge_word.partition} < limits.partition_count);

	assign pos_a = POS_W'(edge_word.partition) * POS_W'(MAX_VERTICES) +
		POS_W'(edge_word.vertex_a);
	assign pos_b = POS_W'(edge_word.partition) * POS_W'(MAX_VERTICES) +
		POS_W'(edge_word.vertex_b);

	// a read issued while the same row was written returns stale data: take the write
	assign rdata_eff = (fwd_valid_q && (fwd_row_q == rd_row_q)) ? fwd_data_q : rdata_q;
	assign new_a     = !rdata_eff[bit_a_q];
	assign new_b     = !rdata_eff[bit_b_q];
	assign count_a   = sat_inc(count_q, new_a);
	assign count_b   = sat_inc(count_q, new_b);
	assign sweep_last = (sweep_q == ROW_AW'(ROWS - 1));

	always_comb begin
		rd_en  = 1'b0;
		rd_row = row_b_q;
		if (accept && (edge_word.action == eprc_pkg::ACT_RECORD) && in_range) begin
			rd_en  = 1'b1;
			rd_row = pos_a[POS_W-1:eprc_pkg::BIT_W];
		end else if (st_q == ST_RDB) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		wr_en     = 1'b0;
		wr_row    = row_a_q;
		wr_data   = '0;
		push      = 1'b0;
		push_word = '0;
		unique case (st_q)
			ST_CLR: begin
				wr_en  = 1'b1;
				wr_row = sweep_q;
				push   = sweep_last && clr_item_q;
			end
			ST_IDLE: begin
			end
			ST_RDB: begin
				wr_en   = 1'b1;
				wr_data = rdata_eff | (eprc_pkg::WORD_W'(1) << bit_a_q);
			end
			ST_WRB: begin
				wr_en   = 1'b1;
				wr_row  = row_b_q;
				wr_data = rdata_eff | (eprc_pkg::WORD_W'(1) << bit_b_q);
				push    = 1'b1;
				push_word.replica_total = count_b;
				push_word.new_replicas  = {1'b0, new_a_q} + {1'b0, new_b};
			end
			ST_ERR: begin
				push = 1'b1;
				push_word.replica_total = count_q;
				push_word.range_error   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rdata_q  <= mem[rd_row];
			rd_row_q <= rd_row;
		end
		fwd_row_q  <= wr_row;
		fwd_data_q <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_a_q <= pos_a[POS_W-1:eprc_pkg::BIT_W];
			bit_a_q <= pos_a[eprc_pkg::BIT_W-1:0];
			row_b_q <= pos_b[POS_W-1:eprc_pkg::BIT_W];
			bit_b_q <= pos_b[eprc_pkg::BIT_W-1:0];
		end
		if (st_q == ST_RDB) begin
			new_a_q <= new_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			sweep_q     <= '0;
			clr_item_q  <= 1'b0;
			count_q     <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
			unique case (st_q)
				ST_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						sweep_q <= '0;
						count_q <= '0;
						st_q    <= ST_IDLE;
					end
				end
				ST_RDB: begin
					count_q <= count_a;
					st_q    <= ST_WRB;
				end
				ST_ERR: begin
					st_q <= ST_IDLE;
				end
				ST_IDLE, ST_WRB: begin
					if (st_q == ST_WRB) begin
						count_q <= count_b;
						st_q    <= ST_IDLE;
					end
					if (accept) begin
						if (edge_word.action == eprc_pkg::ACT_CLEAR) begin
							clr_item_q <= 1'b1;
							st_q       <= ST_CLR;
						end else if (!in_range) begin
							st_q <= ST_ERR;
						end else begin
							st_q <= ST_RDB;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_rdb_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RDB |-> $past(accept))
		else $error("second read without an accepted edge");

	a_wrb_after_rdb: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_WRB |-> $past(st_q) == ST_RDB)
		else $error("write-back of second endpoint out of sequence");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_stat.full)
		else $error("result pushed into full queue");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_CLR |=> count_q >= $past(count_q))
		else $error("replica count fell outside a clear");

endmodule

// ----- design/edge_partition_replica_counter_core.sv -----
// channel  dir  handshake                    fields
// edge     in   edge_valid / edge_stall      edge_word: action, vertex_a, vertex_b, partition
// result   out  result_valid / result_stall  result_word: replica_total, new_replicas, range_error
// cfg      in   cfg_we                       cfg_index, cfg_data
//
// An edge makes one read-modify-write of the bitmap RAM per endpoint; an out-of-range
// edge passes through ST_ERR instead. A clear walks the RAM one 32-bit row a cycle,
// MAX_VERTICES*MAX_PARTITIONS/32 rows (2048 by default), and its word is queued as the
// last row is cleared. After reset the same sweep runs first with edge_stall held high.
// Two result words queue at the output; edges stall once both are held, or once one is
// held while the second endpoint is written back.
module edge_partition_replica_counter_core #(
	parameter int MAX_VERTICES   = 4096,
	parameter int MAX_PARTITIONS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                edge_valid,
	output logic                                edge_stall,
	input  eprc_pkg::edge_word_t                edge_word,
	output logic                                result_valid,
	input  logic                                result_stall,
	output eprc_pkg::result_word_t              result_word,
	input  logic                                cfg_we,
	input  logic [eprc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [eprc_pkg::CFG_W-1:0]          cfg_data
);

	eprc_pkg::cfg_limits_t  limits_q;
	eprc_pkg::fifo_status_t fifo_stat;
	eprc_pkg::result_word_t push_word;
	logic                   push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.vertex_count    <= eprc_pkg::VCOUNT_RESET;
			limits_q.partition_count <= eprc_pkg::PCOUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				eprc_pkg::CFG_VERTEX_COUNT: begin
					limits_q.vertex_count <= cfg_data[eprc_pkg::VCOUNT_W-1:0];
				end
				eprc_pkg::CFG_PARTITION_COUNT: begin
					limits_q.partition_count <= cfg_data[eprc_pkg::PCOUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	eprc_bitmap_core #(
		.MAX_VERTICES   (MAX_VERTICES),
		.MAX_PARTITIONS (MAX_PARTITIONS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_valid (edge_valid),
		.edge_word  (edge_word),
		.edge_stall (edge_stall),
		.limits     (limits_q),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.push_word  (push_word)
	);

	eprc_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_word    (push_word),
		.status       (fifo_stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int TB_MAX_V = 4096;
	localparam int TB_MAX_P = 16;

	// register indices with no register behind them: writes there are ignored
	localparam logic [eprc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [eprc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	logic                           clk;
	logic                           arst_n;
	logic                           edge_valid;
	logic                           edge_stall;
	eprc_pkg::edge_word_t           edge_word;
	logic                           result_valid;
	logic                           result_stall;
	eprc_pkg::result_word_t         result_word;
	logic                           cfg_we;
	logic [eprc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [eprc_pkg::CFG_W-1:0]     cfg_data;

	edge_partition_replica_counter_core #(
		.MAX_VERTICES   (TB_MAX_V),
		.MAX_PARTITIONS (TB_MAX_P)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.edge_valid   (edge_valid),
		.edge_stall   (edge_stall),
		.edge_word    (edge_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// mirror of the block's state
	bit                            membership [TB_MAX_V*TB_MAX_P];
	logic [eprc_pkg::TOTAL_W-1:0]  replica_tally;
	logic [eprc_pkg::VCOUNT_W-1:0] vertex_limit;
	logic [eprc_pkg::PCOUNT_W-1:0] partition_limit;

	eprc_pkg::result_word_t pending_results [$];
	int                     mismatch_count;
	int                     results_seen;
	bit                     edge_held;
	bit                     quiet;
	int                     hold_request;
	int                     hot_base;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("edge_partition_replica_counter_core test failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		else if (r < 98)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	function automatic eprc_pkg::edge_word_t edge_of(logic act, int a, int b, int p);
		eprc_pkg::edge_word_t w;
		w.action    = act;
		w.vertex_a  = eprc_pkg::VERTEX_W'(a);
		w.vertex_b  = eprc_pkg::VERTEX_W'(b);
		w.partition = eprc_pkg::PART_W'(p);
		return w;
	endfunction

	// work out the result word of one accepted edge word and advance the mirror
	task automatic apply_edge(input eprc_pkg::edge_word_t w,
		output eprc_pkg::result_word_t r);
		int                            vlim;
		int                            plim;
		int                            pos;
		logic [eprc_pkg::VERTEX_W-1:0] v;
		r = '0;
		vlim = (vertex_limit < TB_MAX_V) ? int'(vertex_limit) : TB_MAX_V;
		plim = (partition_limit < TB_MAX_P) ? int'(partition_limit) : TB_MAX_P;
		if (w.action == eprc_pkg::ACT_CLEAR) begin
			foreach (membership[i])
				membership[i] = 1'b0;
			replica_tally = '0;
		end else if (w.vertex_a >= vlim || w.vertex_b >= vlim || w.partition >= plim) begin
			r.range_error = 1'b1;
		end else begin
			for (int k = 0; k < 2; k++) begin
				v = k ? w.vertex_b : w.vertex_a;
				pos = int'(w.partition) * TB_MAX_V + int'(v);
				if (!membership[pos]) begin
					membership[pos] = 1'b1;
					r.new_replicas++;
					if (replica_tally != '1)
						replica_tally++;
				end
			end
		end
		r.replica_total = replica_tally;
	endtask

	task automatic send_edge(input eprc_pkg::edge_word_t w);
		int                     gap;
		bit                     taken;
		eprc_pkg::result_word_t r;
		gap = pick_gap();
		if (gap > 0) begin
			if (edge_held)
				edge_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		edge_valid <= 1'b1;
		edge_word  <= w;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !edge_stall;
			@(posedge clk);
		end
		apply_edge(w, r);
		pending_results.push_back(r);
		edge_held = 1'b1;
	endtask

	task automatic edge_rest();
		if (edge_held) begin
			edge_valid <= 1'b0;
			@(posedge clk);
			edge_held = 1'b0;
		end
	endtask

	// drain every outstanding word before touching the limits
	task automatic settle();
		edge_rest();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [eprc_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[eprc_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == eprc_pkg::CFG_VERTEX_COUNT)
			vertex_limit = value[eprc_pkg::VCOUNT_W-1:0];
		else if (idx == eprc_pkg::CFG_PARTITION_COUNT)
			partition_limit = value[eprc_pkg::PCOUNT_W-1:0];
	endtask

	function automatic eprc_pkg::edge_word_t random_edge();
		eprc_pkg::edge_word_t w;
		int                   vlim;
		int                   plim;
		int                   r;
		vlim = (vertex_limit < TB_MAX_V) ? int'(vertex_limit) : TB_MAX_V;
		plim = (partition_limit < TB_MAX_P) ? int'(partition_limit) : TB_MAX_P;
		w = edge_of(eprc_pkg::ACT_RECORD, $urandom, $urandom, $urandom);
		r = $urandom_range(999);
		if (r < 12) begin
			w.action = eprc_pkg::ACT_CLEAR;
		end else if (r >= 90 && vlim > 0 && plim > 0) begin
			// well-formed edge, often around a few hot vertices so bits get hit again
			if ($urandom_range(1)) begin
				w.vertex_a = eprc_pkg::VERTEX_W'((hot_base + $urandom_range(7)) % vlim);
				w.vertex_b = eprc_pkg::VERTEX_W'((hot_base + $urandom_range(7)) % vlim);
			end else begin
				w.vertex_a = eprc_pkg::VERTEX_W'($urandom_range(vlim - 1));
				w.vertex_b = eprc_pkg::VERTEX_W'($urandom_range(vlim - 1));
			end
			if ($urandom_range(9) == 0)
				w.vertex_b = w.vertex_a;
			w.partition = eprc_pkg::PART_W'($urandom_range(plim - 1));
		end
		return w;
	endfunction

	// result side: random stalls, plus a long hold when asked for
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && !quiet) begin
				r = $urandom_range(99);
				if (r < 75)
					stall_left = 0;
				else if (r < 97)
					stall_left = $urandom_range(3, 1);
				else
					stall_left = $urandom_range(60, 15);
			end
			result_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// compare each result word with the oldest expectation
	initial begin
		eprc_pkg::result_word_t want;
		forever begin
			@(negedge clk);
			if (arst_n && result_valid && !result_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d: none expected, got total=%0d new=%0d err=%0d",
							results_seen, result_word.replica_total,
							result_word.new_replicas, result_word.range_error);
				end else begin
					want = pending_results.pop_front();
					if (result_word.replica_total !== want.replica_total ||
						result_word.new_replicas !== want.new_replicas ||
						result_word.range_error !== want.range_error) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("result %0d: expected total=%0d new=%0d err=%0d",
								results_seen, want.replica_total, want.new_replicas,
								want.range_error);
							$display("    got total=%0d new=%0d err=%0d",
								result_word.replica_total, result_word.new_replicas,
								result_word.range_error);
						end
					end
				end
			end
		end
	end

	task automatic test_default_limits();
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 0, 0, 0));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 4095, 4095, 15));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 0, 4095, 15));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 4095, 0, 0));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 2730, 1365, 10));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 1365, 2730, 5));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 1365, 2730, 5));
	endtask

	task automatic test_clear();
		send_edge(edge_of(eprc_pkg::ACT_CLEAR, 4095, 4095, 15));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 4095, 4095, 15));
		send_edge(edge_of(eprc_pkg::ACT_CLEAR, 0, 0, 0));
	endtask

	task automatic test_limit_registers();
		settle();
		write_limit(eprc_pkg::CFG_VERTEX_COUNT, 1);
		write_limit(eprc_pkg::CFG_PARTITION_COUNT, 1);
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 0, 0, 0));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 1, 0, 0));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 0, 1, 0));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 0, 0, 1));
		settle();
		write_limit(eprc_pkg::CFG_VERTEX_COUNT, 0);
		write_limit(CFG_SPARE_LO, 8191);
		write_limit(CFG_SPARE_HI, 8191);
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 0, 0, 0));
		settle();
		write_limit(eprc_pkg::CFG_VERTEX_COUNT, 8191);
		write_limit(eprc_pkg::CFG_PARTITION_COUNT, 0);
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 7, 9, 0));
		settle();
		write_limit(eprc_pkg::CFG_PARTITION_COUNT, 31);
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 4095, 17, 15));
		send_edge(edge_of(eprc_pkg::ACT_RECORD, 0, 0, 0));
		settle();
		write_limit(eprc_pkg::CFG_VERTEX_COUNT, eprc_pkg::VCOUNT_RESET);
		write_limit(eprc_pkg::CFG_PARTITION_COUNT, eprc_pkg::PCOUNT_RESET);
	endtask

	task automatic test_backpressure();
		settle();
		quiet = 1'b1;
		hold_request = 300;
		for (int i = 0; i < 10; i++)
			send_edge(edge_of(eprc_pkg::ACT_RECORD, $urandom_range(4095),
				$urandom_range(4095), $urandom_range(15)));
		settle();
		quiet = 1'b0;
	endtask

	task automatic test_random_edges();
		int vcounts [7] = '{4096, 64, 8, 8191, 1, 2000, 4096};
		int pcounts [7] = '{16, 4, 2, 31, 1, 9, 16};
		for (int ph = 0; ph < 7; ph++) begin
			settle();
			write_limit(eprc_pkg::CFG_VERTEX_COUNT, vcounts[ph]);
			write_limit(eprc_pkg::CFG_PARTITION_COUNT, pcounts[ph]);
			for (int i = 0; i < 260; i++) begin
				if (i % 40 == 0) begin
					quiet = ($urandom_range(3) == 0);
					hot_base = $urandom_range(4095);
				end
				send_edge(random_edge());
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		edge_valid      = 1'b0;
		edge_word       = '0;
		cfg_we          = 1'b0;
		cfg_index       = eprc_pkg::CFG_VERTEX_COUNT;
		cfg_data        = '0;
		edge_held       = 1'b0;
		quiet           = 1'b0;
		hold_request    = 0;
		hot_base        = 0;
		mismatch_count  = 0;
		results_seen    = 0;
		replica_tally   = '0;
		vertex_limit    = eprc_pkg::VCOUNT_RESET;
		partition_limit = eprc_pkg::PCOUNT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_limits();
		test_clear();
		test_limit_registers();
		test_backpressure();
		test_random_edges();

		settle();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("edge_partition_replica_counter_core test passed");
		else
			$display("edge_partition_replica_counter_core test failed");
		$finish;
	end

endmodule
